[hdl/s2i_pkg.sv]
// ----------------------------------------------------------------------------
// s2i_pkg
// Shared types, character codes and digit decoding for the string to integer
// parser.
// ----------------------------------------------------------------------------
package s2i_pkg;

    typedef enum logic [2:0] {
        PH_WS,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } s2i_phase_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_INVALID,
        ERR_RANGE
    } s2i_err_t;

    typedef struct packed {
        s2i_phase_t  phase;
        logic        is_negative;
        logic        sign_seen;
        logic        zero_pending;
        logic        digit_seen;
        logic [5:0]  base;
    } s2i_ctrl_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] BASE_UNARY = 6'd1;
    localparam logic [5:0] BASE_MIN   = 6'd2;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] BASE_MAX   = 6'd36;
    localparam logic [5:0] DIGIT_NONE = 6'd63;
    localparam logic [5:0] LETTER_OFS = 6'd10;

    localparam s2i_ctrl_t CTRL_CLEAR = '{
        phase:        PH_WS,
        is_negative:  1'b0,
        sign_seen:    1'b0,
        zero_pending: 1'b0,
        digit_seen:   1'b0,
        base:         BASE_DEC
    };

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [5:0] d;
        d = DIGIT_NONE;
        if (c inside {[CH_ZERO:CH_NINE]})
            d = 6'(c - CH_ZERO);
        else if (c inside {[CH_UPPER_A:CH_UPPER_Z]})
            d = 6'(c - CH_UPPER_A) + LETTER_OFS;
        else if (c inside {[CH_LOWER_A:CH_LOWER_Z]})
            d = 6'(c - CH_LOWER_A) + LETTER_OFS;
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

endpackage

[hdl/string_to_integer_parser_unit.sv]
// ----------------------------------------------------------------------------
// string_to_integer_parser_unit
// Parses a character stream into a signed integer, one character per item,
// with whitespace, sign, base prefix, saturation and error reporting.
// Characters are registered in in_ch_reg, results in the m_axis output registers.
// Throughput: one character per cycle while no result waits on m_axis_tready;
// the base multiply, add and limit compare of the state update are combinational.
// Reset: clears the parse state to a base 10 string starting at reset, radix 10.
// ----------------------------------------------------------------------------
module string_to_integer_parser_unit
    import s2i_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int POS_BITS   = 16
)
(
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            cfg_valid,
    output logic                                            cfg_ready,
    input  logic [5:0]                                      cfg_data,      // radix
    input  logic                                            s_axis_tvalid,
    output logic                                            s_axis_tready,
    input  logic [7:0]                                      s_axis_tdata,  // ch
    input  logic                                            s_axis_tuser,  // start_req
    output logic                                            m_axis_tvalid,
    input  logic                                            m_axis_tready,
    // value, end_offset, error_code, zero fill
    output logic [((VALUE_BITS+POS_BITS+2+7)/8)*8-1:0]      m_axis_tdata
);

    localparam int TDATA_W = ((VALUE_BITS + POS_BITS + 2 + 7) / 8) * 8;

    logic [5:0]            radix_reg;
    logic                  in_valid_reg;
    logic [7:0]            in_ch_reg;
    logic                  in_start_reg;
    s2i_ctrl_t             ctrl_reg;
    logic [VALUE_BITS-1:0] acc_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [POS_BITS-1:0]   sign_off_reg;
    logic                  out_valid_reg;
    logic [VALUE_BITS-1:0] out_value_reg;
    logic [POS_BITS-1:0]   out_off_reg;
    s2i_err_t              out_err_reg;

    s2i_ctrl_t             ctrl_next;
    logic [VALUE_BITS-1:0] acc_next;
    logic [POS_BITS-1:0]   pos_next;
    logic [POS_BITS-1:0]   sign_off_next;
    logic                  emit;
    logic [VALUE_BITS-1:0] res_value;
    logic [POS_BITS-1:0]   res_off;
    s2i_err_t              res_err;
    logic                  adv;
    logic                  out_valid_next;

    s2i_step #(
        .VALUE_BITS (VALUE_BITS),
        .POS_BITS   (POS_BITS)
    ) u_step (
        .ch               (in_ch_reg),
        .start_req        (in_start_reg),
        .radix            (radix_reg),
        .ctrl             (ctrl_reg),
        .acc              (acc_reg),
        .position         (pos_reg),
        .sign_offset      (sign_off_reg),
        .ctrl_next        (ctrl_next),
        .acc_next         (acc_next),
        .position_next    (pos_next),
        .sign_offset_next (sign_off_next),
        .emit             (emit),
        .value            (res_value),
        .end_offset       (res_off),
        .error_code       (res_err)
    );

    assign cfg_ready      = 1'b1;
    assign adv            = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || adv;
    assign m_axis_tvalid  = out_valid_reg;
    assign m_axis_tdata   = TDATA_W'({out_err_reg, out_off_reg, out_value_reg});
    assign out_valid_next = (adv && emit) || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= BASE_DEC;
            in_valid_reg  <= 1'b0;
            in_start_reg  <= 1'b0;
            ctrl_reg      <= CTRL_CLEAR;
            acc_reg       <= '0;
            pos_reg       <= '0;
            sign_off_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                radix_reg <= cfg_data;
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
                in_start_reg <= s_axis_tuser;
            end
            if (adv)
            begin
                ctrl_reg     <= ctrl_next;
                acc_reg      <= acc_next;
                pos_reg      <= pos_next;
                sign_off_reg <= sign_off_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready)
            in_ch_reg <= s_axis_tdata;
        if (adv && emit)
        begin
            out_value_reg <= res_value;
            out_off_reg   <= res_off;
            out_err_reg   <= res_err;
        end
    end

    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        adv && emit |=> ctrl_reg.phase == PH_DONE)
        else $error("parser did not stop after a result");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        adv && !in_start_reg && ctrl_reg.phase == PH_DONE |-> !emit)
        else $error("result after stop without a new string");

    a_range_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg == ERR_RANGE |->
            out_value_reg == {1'b0, {(VALUE_BITS-1){1'b1}}} ||
            out_value_reg == {1'b1, {(VALUE_BITS-1){1'b0}}})
        else $error("out of range result not saturated");

endmodule

[hdl/s2i_step.sv]
// ----------------------------------------------------------------------------
// s2i_step
// Next-state and result logic for one character: phase control, prefix
// handling, digit accumulation with exact overflow check.
// ----------------------------------------------------------------------------
module s2i_step
    import s2i_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int POS_BITS   = 16
)
(
    input  logic [7:0]            ch,
    input  logic                  start_req,
    input  logic [5:0]            radix,
    input  s2i_ctrl_t             ctrl,
    input  logic [VALUE_BITS-1:0] acc,
    input  logic [POS_BITS-1:0]   position,
    input  logic [POS_BITS-1:0]   sign_offset,
    output s2i_ctrl_t             ctrl_next,
    output logic [VALUE_BITS-1:0] acc_next,
    output logic [POS_BITS-1:0]   position_next,
    output logic [POS_BITS-1:0]   sign_offset_next,
    output logic                  emit,
    output logic [VALUE_BITS-1:0] value,
    output logic [POS_BITS-1:0]   end_offset,
    output s2i_err_t              error_code
);

    localparam int PROD_BITS = VALUE_BITS + 6;

    s2i_ctrl_t             cur;
    logic [VALUE_BITS-1:0] acc_cur;
    logic [POS_BITS-1:0]   pos;
    logic [POS_BITS-1:0]   sign_off_cur;
    logic                  bad_radix;
    logic                  drop;
    logic                  prefix_zero;
    logic                  take_digit;
    logic [5:0]            dig_base;
    logic                  dig_ds;
    logic                  pre_zero;
    logic                  set_hex;
    logic                  set_oct;
    logic                  set_sign;
    logic [5:0]            base_eff;
    logic [5:0]            d;
    logic [PROD_BITS-1:0]  prod;
    logic [PROD_BITS-1:0]  sum;
    logic [PROD_BITS-1:0]  lim;
    logic                  is_nul;
    logic                  fin;
    logic                  rng;
    logic                  accum;
    s2i_phase_t            phase_next;

    always_comb
    begin
        cur          = ctrl;
        acc_cur      = acc;
        pos          = position;
        sign_off_cur = sign_offset;
        if (start_req)
        begin
            cur          = CTRL_CLEAR;
            cur.base     = radix;
            acc_cur      = '0;
            pos          = '0;
            sign_off_cur = '0;
        end
        bad_radix   = start_req && ((radix == BASE_UNARY) || (radix > BASE_MAX));
        drop        = !start_req && (ctrl.phase == PH_DONE);
        prefix_zero = ((cur.base == BASE_AUTO) || (cur.base == BASE_HEX)) && (ch == CH_ZERO);

        take_digit = 1'b0;
        dig_base   = cur.base;
        dig_ds     = cur.digit_seen;
        pre_zero   = 1'b0;
        set_hex    = 1'b0;
        set_oct    = 1'b0;
        set_sign   = 1'b0;
        case (cur.phase)
            PH_WS, PH_PREFIX:
            begin
                if (cur.phase == PH_WS && is_space(ch))
                    take_digit = 1'b0;
                else if (cur.phase == PH_WS && (ch == CH_MINUS || ch == CH_PLUS))
                    set_sign = 1'b1;
                else if (prefix_zero)
                    pre_zero = 1'b1;
                else
                begin
                    take_digit = 1'b1;
                    if (cur.base == BASE_AUTO)
                        dig_base = BASE_DEC;
                end
            end
            PH_ZERO:
            begin
                if (ch == CH_LOWER_X)
                    set_hex = 1'b1;
                else if (cur.base == BASE_AUTO && ch == CH_ZERO)
                    set_oct = 1'b1;
                else
                begin
                    take_digit = 1'b1;
                    dig_ds     = 1'b1;
                    if (cur.base == BASE_AUTO)
                        dig_base = BASE_DEC;
                end
            end
            PH_DIGITS:
                take_digit = 1'b1;
            default:
                take_digit = 1'b0;
        endcase
    end

    always_comb
    begin
        base_eff = ((dig_base < BASE_MIN) || (dig_base > BASE_MAX)) ? BASE_DEC : dig_base;
        d        = digit_of(ch);
        prod     = PROD_BITS'(acc_cur) * PROD_BITS'(base_eff);
        sum      = prod + PROD_BITS'(d);
        lim      = PROD_BITS'({1'b0, {(VALUE_BITS-1){1'b1}}}) + PROD_BITS'(cur.is_negative);
        is_nul   = (ch == CH_NUL);
        fin      = take_digit && (is_nul || (d >= base_eff));
        rng      = take_digit && !fin && (sum > lim);
        accum    = take_digit && !fin && !rng;
    end

    always_comb
    begin
        if (drop)
            phase_next = ctrl.phase;
        else if (bad_radix || fin || rng)
            phase_next = PH_DONE;
        else if (pre_zero)
            phase_next = PH_ZERO;
        else if (set_sign)
            phase_next = PH_PREFIX;
        else if (take_digit || set_hex || set_oct)
            phase_next = PH_DIGITS;
        else
            phase_next = cur.phase;
    end

    always_comb
    begin
        ctrl_next        = ctrl;
        acc_next         = acc;
        position_next    = position;
        sign_offset_next = sign_offset;
        emit             = 1'b0;
        value            = '0;
        end_offset       = pos;
        error_code       = ERR_NONE;
        if (!drop)
        begin
            ctrl_next             = cur;
            ctrl_next.phase       = phase_next;
            ctrl_next.is_negative = set_sign ? (ch == CH_MINUS) : cur.is_negative;
            ctrl_next.sign_seen   = cur.sign_seen || set_sign;
            ctrl_next.zero_pending = pre_zero ? 1'b1 :
                                     ((cur.phase == PH_ZERO) ? 1'b0 : cur.zero_pending);
            ctrl_next.digit_seen  = take_digit ? (dig_ds || accum) : cur.digit_seen;
            if (set_hex)
                ctrl_next.base = BASE_HEX;
            else if (set_oct)
                ctrl_next.base = BASE_OCT;
            else if (take_digit)
                ctrl_next.base = base_eff;
            acc_next         = accum ? sum[VALUE_BITS-1:0] : acc_cur;
            position_next    = pos + POS_BITS'(1);
            sign_offset_next = set_sign ? pos : sign_off_cur;

            if (bad_radix)
            begin
                ctrl_next       = CTRL_CLEAR;
                ctrl_next.phase = PH_DONE;
                acc_next        = '0;
                position_next   = '0;
                emit            = 1'b1;
                end_offset      = '0;
                error_code      = ERR_INVALID;
            end
            else if (fin)
            begin
                emit = 1'b1;
                if (dig_ds)
                    value = cur.is_negative ? (-acc_cur) : acc_cur;
                else if (!is_nul)
                    error_code = ERR_INVALID;
                else if (cur.sign_seen)
                begin
                    error_code = ERR_INVALID;
                    end_offset = sign_off_cur;
                end
            end
            else if (rng)
            begin
                emit       = 1'b1;
                value      = lim[VALUE_BITS-1:0];
                error_code = ERR_RANGE;
            end
        end
    end

endmodule
